// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while rst is high
`define BIPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define BIPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bipf_pkg.sv =====
package bipf_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 31;
  localparam int ORD_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int GRP_SIZE = 32;
  localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_ROOT  = 2'd1,
    ST_DUP   = 2'd2,
    ST_FULL  = 2'd3
  } bipf_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_UPD
  } bipf_state_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ORD_W-1:0] ord;
    logic             valid;
    logic             lt;
  } bipf_link_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ORD_W-1:0] ord;
    logic             ins;
    logic [CNT_W-1:0] count;
  } bipf_ctrl_t;

  // reduction result over the whole row
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             dup;
  } bipf_hit_t;

  // left of the first cell acts as a smaller, absent key
  localparam bipf_link_t LINK_HEAD = '{key: '0, ord: '0, valid: 1'b0, lt: 1'b1};
  localparam bipf_link_t LINK_TAIL = '{key: '0, ord: '0, valid: 1'b0, lt: 1'b0};

endpackage

// ===== src/bipf_ifs.sv =====
interface bipf_req_if import bipf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink (input valid, input key, output ready);
endinterface

interface bipf_rsp_if import bipf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] parent_key;
  logic [1:0]       status;

  modport source (output valid, output parent_key, output status, input ready);
  modport sink (input valid, input parent_key, input status, output ready);
endinterface

// ===== src/bipf_cell.sv =====
module bipf_cell import bipf_pkg::*; (
  input  logic             clk,
  input  logic [ORD_W-1:0] idx,
  input  bipf_ctrl_t       ctrl,
  input  bipf_link_t       left,
  input  bipf_link_t       right,
  output bipf_link_t       link,
  output logic             eq,
  output logic             sel
);

  logic [KEY_W-1:0] key;
  logic [ORD_W-1:0] ord;
  logic             lt;
  logic             valid;
  logic             pred;
  logic             succ;

  // stored entries form a prefix of the row
  assign valid = CNT_W'(idx) < ctrl.count;

  always_ff @(posedge clk) begin
    lt <= valid && (key < ctrl.key);
    eq <= valid && (key == ctrl.key);
    if (ctrl.ins && !lt) begin
      if (left.lt) begin
        key <= ctrl.key;
        ord <= ctrl.ord;
      end else begin
        key <= left.key;
        ord <= left.ord;
      end
    end
  end

  // last smaller key and first larger key
  assign pred = lt && !right.lt;
  assign succ = valid && !lt && left.lt;

  // the later inserted neighbor becomes the parent
  assign sel = (pred && (!right.valid || ord > right.ord)) ||
               (succ && (!left.valid || ord > left.ord));

  assign link = '{key: key, ord: ord, valid: valid, lt: lt};

endmodule

// ===== src/bipf_reduce.sv =====
module bipf_reduce import bipf_pkg::*; (
  input  logic                      clk,
  input  bipf_link_t [CAPACITY-1:0] links,
  input  logic [CAPACITY-1:0]       sel,
  input  logic [CAPACITY-1:0]       eq,
  output bipf_hit_t                 hit
);

  logic [NUM_GRP-1:0][KEY_W-1:0] grp_key;
  logic [NUM_GRP-1:0][KEY_W-1:0] grp_key_next;
  logic [NUM_GRP-1:0]            grp_dup;
  logic [NUM_GRP-1:0]            grp_dup_next;

  // first level: one group of cells per register
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_key_next[g] = '0;
      grp_dup_next[g] = 1'b0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (g * GRP_SIZE + j < CAPACITY) begin
          grp_key_next[g] = grp_key_next[g] |
                            (sel[g * GRP_SIZE + j] ? links[g * GRP_SIZE + j].key : '0);
          grp_dup_next[g] = grp_dup_next[g] | eq[g * GRP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_key <= grp_key_next;
    grp_dup <= grp_dup_next;
  end

  // second level over the group registers
  always_comb begin
    hit.key = '0;
    hit.dup = 1'b0;
    for (int g = 0; g < NUM_GRP; g++) begin
      hit.key = hit.key | grp_key[g];
      hit.dup = hit.dup | grp_dup[g];
    end
  end

endmodule

// ===== src/bst_insert_parent_finder_unit.sv =====
// a key passes through the states S_CMP, S_RED and S_UPD before its result shows on rsp;
// one key at a time, and a new key waits while a result is held on rsp: compare in every cell, registered
// two-level reduction across the cell row, then the row shifts to insert
// reset: synchronous active-high rst empties the set and drops rsp.valid;
// stored cells are not cleared, the key count alone marks them valid
module bst_insert_parent_finder_unit import bipf_pkg::*; (
  input logic          clk,
  input logic          rst,
  bipf_req_if.sink     req,
  bipf_rsp_if.source   rsp
);

  bipf_state_t               state;
  bipf_state_t               state_next;
  logic [KEY_W-1:0]          key;
  logic [CNT_W-1:0]          count;
  bipf_ctrl_t                ctrl;
  bipf_link_t [CAPACITY-1:0] links;
  logic [CAPACITY-1:0]       sel;
  logic [CAPACITY-1:0]       eq;
  bipf_hit_t                 hit;
  bipf_status_t              status_next;
  logic                      ins;
  logic                      accept;
  logic                      rsp_valid;
  logic [KEY_W-1:0]          parent_key;
  bipf_status_t              status;

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_CMP;
      S_CMP:  state_next = S_RED;
      S_RED:  state_next = S_UPD;
      S_UPD:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = !rst && (state == S_IDLE) && (!rsp_valid || rsp.ready);
    ins       = (state == S_UPD) && (status_next == ST_ROOT || status_next == ST_FOUND);
  end

  always_comb begin
    if (count == '0) begin
      status_next = ST_ROOT;
    end else if (hit.dup) begin
      status_next = ST_DUP;
    end else if (count == CNT_W'(CAPACITY)) begin
      status_next = ST_FULL;
    end else begin
      status_next = ST_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key <= req.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ins) begin
      count <= count + CNT_W'(1);
    end
  end

  assign ctrl = '{key: key, ord: count[ORD_W-1:0], ins: ins, count: count};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bipf_link_t left;
    bipf_link_t right;
    if (i == 0) begin : g_head
      assign left = LINK_HEAD;
    end else begin : g_mid_l
      assign left = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = LINK_TAIL;
    end else begin : g_mid_r
      assign right = links[i+1];
    end
    bipf_cell u_cell (
      .clk   (clk),
      .idx   (ORD_W'(i)),
      .ctrl  (ctrl),
      .left  (left),
      .right (right),
      .link  (links[i]),
      .eq    (eq[i]),
      .sel   (sel[i])
    );
  end

  bipf_reduce u_reduce (
    .clk   (clk),
    .links (links),
    .sel   (sel),
    .eq    (eq),
    .hit   (hit)
  );

  // result register parts the row from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_UPD) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      status     <= status_next;
      parent_key <= (status_next == ST_FOUND) ? hit.key : '0;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.parent_key = parent_key;
  assign rsp.status     = status;

endmodule

// ===== src/bipf_checker.sv =====
`include "assert_macros.svh"

module bipf_checker import bipf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [KEY_W-1:0] parent_key,
  input logic [1:0]       status
);

  // parent key is only reported with a found parent
  `BIPF_ASSERT(a_parent_zero, rsp_valid |-> (status == ST_FOUND || parent_key == '0), "parent_key set without found status")

  // one key at a time: no transfer right after a transfer
  `BIPF_ASSERT(a_one_in_flight, (req_valid && req_ready) |=> !req_ready, "input taken while a key is in work")

  // every new result comes from a key taken by an earlier input transfer
  `BIPF_ASSERT(a_result_source, $rose(rsp_valid) |-> $past(req_valid && req_ready, 4), "result without a matching input transfer")

  `BIPF_ASSERT_ALWAYS(a_reset_clears, rst |=> !rsp_valid, "result valid after reset")

endmodule

bind bst_insert_parent_finder_unit bipf_checker u_bipf_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .parent_key (rsp.parent_key),
  .status     (rsp.status)
);
